// ===== hw/rtl/pee_pkg.sv =====
`default_nettype none
package pee_pkg;
	localparam int unsigned StackDepthDef  = 32;
	localparam int unsigned MaxExponentDef = 64;
	localparam int unsigned QueueDepth     = 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_POW = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_DIVZ  = 3'd3,
		ST_SAT   = 3'd4
	} status_t;

	typedef struct packed {
		logic        kind;
		logic [63:0] value;
		logic [2:0]  op;
		logic        last;
	} token_t;

	localparam logic [63:0] QOne    = 64'h0000_0001_0000_0000;
	localparam logic [63:0] QMaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] QMinNeg = 64'h8000_0000_0000_0000;
endpackage
`default_nettype wire

// ===== hw/rtl/pee_front.sv =====
`default_nettype none
module pee_front
	import pee_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        kind,
	input  wire logic [63:0] token_value,
	input  wire logic [2:0]  op_code,
	input  wire logic        last,
	input  wire logic        in_valid,
	output logic             in_ready,
	output token_t           tok,
	output logic             tok_valid,
	input  wire logic        tok_ready
);
	localparam int unsigned PtrW = $clog2(QueueDepth);

	token_t              q_mem_q [QueueDepth];
	logic [PtrW-1:0]     wr_q, rd_q;
	logic [PtrW:0]       cnt_q;
	logic                push, pop;

	assign in_ready  = (cnt_q != (PtrW+1)'(QueueDepth));
	assign tok_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = tok_valid && tok_ready;
	assign tok       = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_q] <= '{kind: kind, value: token_value, op: op_code, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/pee_alu.sv =====
`default_nettype none
module pee_alu
	import pee_pkg::*;
#(
	parameter int unsigned MAX_EXPONENT = MaxExponentDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [2:0]  op,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      res,
	output logic             sat,
	output logic             divz
);
	localparam int unsigned CntW = $clog2(MAX_EXPONENT + 1);

	typedef enum logic [3:0] {
		A_IDLE, A_ASUB, A_MUL0, A_MUL1, A_MUL2, A_MUL3, A_MULF, A_POWN, A_DIV, A_DIVF,
		A_DONE
	} alu_state_t;

	alu_state_t  state_q, state_d;
	logic [63:0] a_q, b_q, acc_q, res_q;
	logic [2:0]  op_q;
	logic        sat_q, divz_q, pow_q, pneg_q;
	logic [CntW-1:0] pcnt_q;
	logic [63:0] ma_q, mb_q;
	logic        neg_q;
	logic [127:0] prod_q;
	logic [1:0]  part_q;
	logic [63:0] rem_q, quo_q;
	logic        big_q;
	logic [6:0]  dcnt_q;
	logic [63:0] sum, dif, mres, dres;
	logic        ssat, dsat, msat, qsat;
	logic [31:0] pa, pb;
	logic [64:0] rem_sh;
	logic [63:0] ma_c, mb_c;

	function automatic logic [63:0] mag(input logic [63:0] x);
		return x[63] ? (~x + 64'd1) : x;
	endfunction

	function automatic logic [64:0] sgn_sat(input logic neg, input logic [63:0] m,
		input logic big);
		logic [63:0] lim;
		logic        s;
		logic [63:0] v;
		lim = neg ? QMinNeg : QMaxPos;
		s = big || (m > lim);
		v = s ? lim : m;
		return {s, (neg ? (~v + 64'd1) : v)};
	endfunction

	function automatic logic [CntW-1:0] pow_cnt(input logic [63:0] e);
		logic [63:0] m;
		logic [32:0] c;
		m = mag(e);
		c = {1'b0, m[63:32]} + 33'(m[31:0] != '0);
		return (c > 33'(MAX_EXPONENT)) ? CntW'(MAX_EXPONENT) : CntW'(c);
	endfunction

	assign sum = a_q + b_q;
	assign dif = a_q - b_q;
	assign ssat = (a_q[63] == b_q[63]) && (sum[63] != a_q[63]);
	assign dsat = (a_q[63] != b_q[63]) && (dif[63] != a_q[63]);
	assign {msat, mres} = sgn_sat(neg_q, prod_q[95:32], prod_q[127:96] != '0);
	assign {qsat, dres} = sgn_sat(neg_q, quo_q, big_q);
	assign pa = part_q[0] ? ma_q[63:32] : ma_q[31:0];
	assign pb = part_q[1] ? mb_q[63:32] : mb_q[31:0];
	assign rem_sh = {rem_q, (dcnt_q >= 7'd32) ? ma_q[6'(dcnt_q - 7'd32)] : 1'b0};
	assign ma_c = mag(a);
	assign mb_c = mag(b);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: if (start) begin
				unique case (op)
					OP_MUL: state_d = A_MUL0;
					OP_DIV: state_d = A_DIV;
					OP_POW: state_d = A_POWN;
					default: state_d = A_ASUB;
				endcase
			end
			A_ASUB: state_d = A_DONE;
			A_MUL0: state_d = A_MUL1;
			A_MUL1: state_d = A_MUL2;
			A_MUL2: state_d = A_MUL3;
			A_MUL3: state_d = A_MULF;
			A_MULF: state_d = pow_q ? A_POWN : A_DONE;
			A_POWN: state_d = (pcnt_q != '0) ? A_MUL0 : (pneg_q ? A_DIV : A_DONE);
			A_DIV:  state_d = (dcnt_q == '0) ? A_DIVF : A_DIV;
			A_DIVF: state_d = A_DONE;
			A_DONE: state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: if (start) begin
				a_q <= a;
				b_q <= b;
				op_q <= op;
				sat_q <= 1'b0;
				divz_q <= 1'b0;
				pow_q <= (op == OP_POW);
				if (op == OP_POW) begin
					ma_q <= QOne;
					mb_q <= ma_c;
					neg_q <= a[63];
				end else begin
					ma_q <= ma_c;
					mb_q <= mb_c;
					neg_q <= a[63] ^ b[63];
				end
				prod_q <= '0;
				part_q <= '0;
				rem_q <= '0;
				quo_q <= '0;
				big_q <= 1'b0;
				dcnt_q <= 7'd95;
				acc_q <= QOne;
				pcnt_q <= pow_cnt(b);
				pneg_q <= b[63];
			end
			A_ASUB: begin
				unique case (op_q)
					OP_ADD: begin
						res_q <= ssat ? (a_q[63] ? QMinNeg : QMaxPos) : sum;
						sat_q <= ssat;
					end
					OP_SUB: begin
						res_q <= dsat ? (a_q[63] ? QMinNeg : QMaxPos) : dif;
						sat_q <= dsat;
					end
					default: res_q <= '0;
				endcase
			end
			A_MUL0, A_MUL1, A_MUL2, A_MUL3: begin
				prod_q <= prod_q + ({64'd0, 32'd0, pa} * {96'd0, pb}
					<< (32 * (32'(part_q[0]) + 32'(part_q[1]))));
				part_q <= part_q + 2'd1;
			end
			A_MULF: begin
				if (pow_q) begin
					if (msat) sat_q <= 1'b1;
					acc_q <= mres;
					ma_q <= mag(mres);
					neg_q <= mres[63] ^ a_q[63];
					prod_q <= '0;
					part_q <= '0;
				end else begin
					res_q <= mres;
					sat_q <= msat;
				end
			end
			A_POWN: begin
				if (pcnt_q != '0) begin
					pcnt_q <= pcnt_q - 1'b1;
				end else if (pneg_q) begin
					ma_q <= QOne;
					mb_q <= mag(acc_q);
					neg_q <= acc_q[63];
					rem_q <= '0;
					quo_q <= '0;
					big_q <= 1'b0;
					dcnt_q <= 7'd95;
					pow_q <= 1'b0;
				end else begin
					res_q <= acc_q;
				end
			end
			A_DIV: begin
				if (quo_q[63]) big_q <= 1'b1;
				if (rem_sh >= {1'b0, mb_q}) begin
					rem_q <= 64'(rem_sh - {1'b0, mb_q});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 7'd1;
			end
			A_DIVF: begin
				if (mb_q == '0) begin
					res_q <= '0;
					divz_q <= 1'b1;
				end else begin
					res_q <= dres;
					if (qsat) sat_q <= 1'b1;
				end
			end
			A_DONE: ;
			default: ;
		endcase
	end

	assign done = (state_q == A_DONE);
	assign res  = res_q;
	assign sat  = sat_q;
	assign divz = divz_q;
endmodule
`default_nettype wire

// ===== hw/rtl/pee_back.sv =====
`default_nettype none
module pee_back
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH  = StackDepthDef,
	parameter int unsigned MAX_EXPONENT = MaxExponentDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  token_t           tok,
	input  wire logic        tok_valid,
	output logic             tok_ready,
	output logic [63:0]      result_value,
	output logic [2:0]       status,
	output logic             out_valid,
	input  wire logic        out_ready
);
	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {B_IDLE, B_RD, B_EXEC, B_WAIT, B_FIN, B_TOP} back_state_t;

	back_state_t  state_q, state_d;
	logic [63:0]  stk_mem [STACK_DEPTH];
	logic [63:0]  rd_data_q, first_q;
	logic [CW-1:0] cnt_q;
	logic [2:0]   err_q;
	token_t       tok_q;
	logic         alu_start, alu_done, alu_sat, alu_divz;
	logic [63:0]  alu_res;
	logic [AW-1:0] rd_addr;
	logic         rd_en, wr_en;
	logic [AW-1:0] wr_addr;
	logic [63:0]  wr_data;
	logic [63:0]  out_val_q;
	logic [2:0]   out_st_q;
	logic         out_v_q;
	logic         rd_first_q;

	pee_alu #(.MAX_EXPONENT(MAX_EXPONENT)) u_alu (
		.clk(clk), .arst_n(arst_n), .start(alu_start), .op(tok_q.op),
		.a(first_q), .b(rd_data_q), .done(alu_done), .res(alu_res),
		.sat(alu_sat), .divz(alu_divz)
	);

	always_ff @(posedge clk) begin
		if (wr_en) stk_mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= stk_mem[rd_addr];
	end

	assign tok_ready = (state_q == B_IDLE);

	always_comb begin
		state_d   = state_q;
		alu_start = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = tok_q.value;
		unique case (state_q)
			B_IDLE: if (tok_valid && tok_ready) state_d = B_RD;
			B_RD: begin
				if (!tok_q.kind) begin
					if (cnt_q != CW'(STACK_DEPTH)) begin
						wr_en = 1'b1;
						wr_addr = AW'(cnt_q);
					end
					state_d = B_FIN;
				end else if (cnt_q < CW'(2)) begin
					state_d = B_FIN;
				end else begin
					rd_en = 1'b1;
					rd_addr = AW'(cnt_q - CW'(2));
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				if (rd_first_q) begin
					rd_en = 1'b1;
					rd_addr = AW'(cnt_q - CW'(1));
				end else begin
					alu_start = 1'b1;
					state_d = B_WAIT;
				end
			end
			B_WAIT: if (alu_done) begin
				wr_en = 1'b1;
				wr_addr = AW'(cnt_q - CW'(2));
				wr_data = alu_res;
				state_d = B_FIN;
			end
			B_FIN: begin
				if (!tok_q.last) begin
					state_d = B_IDLE;
				end else if (!out_v_q) begin
					if (cnt_q != '0) begin
						rd_en = 1'b1;
						rd_addr = AW'(cnt_q - CW'(1));
						state_d = B_TOP;
					end else state_d = B_IDLE;
				end
			end
			B_TOP: state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q <= '0;
			err_q <= ST_OK;
			out_v_q <= 1'b0;
			out_val_q <= '0;
			out_st_q <= ST_OK;
			rd_first_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				B_IDLE: ;
				B_RD: begin
					if (!tok_q.kind) begin
						if (cnt_q != CW'(STACK_DEPTH)) cnt_q <= cnt_q + 1'b1;
						else if (err_q == ST_OK) err_q <= ST_OVER;
					end else if (cnt_q < CW'(2)) begin
						if (err_q == ST_OK) err_q <= ST_UNDER;
					end
					rd_first_q <= 1'b1;
				end
				B_EXEC: rd_first_q <= 1'b0;
				B_WAIT: if (alu_done) begin
					cnt_q <= cnt_q - 1'b1;
					if (err_q == ST_OK) begin
						if (alu_divz) err_q <= ST_DIVZ;
						else if (alu_sat) err_q <= ST_SAT;
					end
				end
				B_FIN: if (tok_q.last && !out_v_q) begin
					if (cnt_q == '0) begin
						out_st_q <= (err_q == ST_OK) ? ST_UNDER : err_q;
						out_val_q <= '0;
						out_v_q <= 1'b1;
						err_q <= ST_OK;
					end else out_st_q <= err_q;
				end
				B_TOP: begin
					out_val_q <= rd_data_q;
					out_v_q <= 1'b1;
					cnt_q <= '0;
					err_q <= ST_OK;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && tok_valid && tok_ready) tok_q <= tok;
		if (state_q == B_EXEC && rd_first_q) first_q <= rd_data_q;
	end

	assign result_value = out_val_q;
	assign status       = out_st_q;
	assign out_valid    = out_v_q;
endmodule
`default_nettype wire

// ===== hw/rtl/postfix_expression_evaluator_unit.sv =====
// channel | valid     | ready     | words
// in      | in_valid  | in_ready  | kind, token_value, op_code, last
// out     | out_valid | out_ready | result_value, status
// Back end per token: a number is pushed; add/subtract, multiply and divide read two operands
// and run in the ALU, divide at one quotient bit a cycle over 96 bits; a last token on a
// nonempty stack adds a read of the top. Power runs ceil(|exponent|) multiply steps, capped
// at MAX_EXPONENT, then a divide under a negative exponent.
// A two-word queue decouples input; a pending result stalls the back only at a last token.
// Reset clears the stack count, status and queue; stack contents are not cleared.
`default_nettype none
module postfix_expression_evaluator_unit
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH  = StackDepthDef,
	parameter int unsigned MAX_EXPONENT = MaxExponentDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [63:0] token_value,
	input  wire logic [2:0]  op_code,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_value,
	output logic [2:0]       status
);
	token_t tok;
	logic   tok_valid, tok_ready;

	pee_front u_front (
		.clk(clk), .arst_n(arst_n), .kind(kind), .token_value(token_value),
		.op_code(op_code), .last(last), .in_valid(in_valid), .in_ready(in_ready),
		.tok(tok), .tok_valid(tok_valid), .tok_ready(tok_ready)
	);

	pee_back #(.STACK_DEPTH(STACK_DEPTH), .MAX_EXPONENT(MAX_EXPONENT)) u_back (
		.clk(clk), .arst_n(arst_n), .tok(tok), .tok_valid(tok_valid),
		.tok_ready(tok_ready), .result_value(result_value), .status(status),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	a_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
		else $error("result dropped under stall");
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready))
		else $error("input ready unknown");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_SAT)
		else $error("bad status");
endmodule
`default_nettype wire

// ===== tb/tb_postfix_expression_evaluator_unit.sv =====
module tb_postfix_expression_evaluator_unit;
	import pee_pkg::*;

	localparam int unsigned WatchdogLimit = 20000;
	localparam int unsigned HoldCycles    = 3000;

	typedef struct {
		logic [63:0] value;
		status_t     st;
	} rpn_answer_t;

	class rpn_scoreboard;
		logic [63:0]   stack_mem [StackDepthDef];
		int unsigned   depth;
		status_t       err;
		rpn_answer_t   answers [$];
		int unsigned   errors;
		int unsigned   tokens_seen;
		int unsigned   exprs_seen;

		function new();
			depth = 0;
			err = ST_OK;
			errors = 0;
			tokens_seen = 0;
			exprs_seen = 0;
		endfunction

		function void flag(status_t code);
			if (err == ST_OK) begin
				err = code;
			end
		endfunction

		function logic [63:0] mag(logic [63:0] x);
			return x[63] ? (~x + 64'd1) : x;
		endfunction

		function logic [63:0] clamp(bit neg, logic [63:0] m, bit big);
			logic [63:0] lim;
			lim = neg ? QMinNeg : QMaxPos;
			if (big || m > lim) begin
				flag(ST_SAT);
				m = lim;
			end
			return neg ? (~m + 64'd1) : m;
		endfunction

		function logic [63:0] q_add(logic [63:0] a, logic [63:0] b);
			logic [63:0] r;
			r = a + b;
			if (a[63] == b[63] && r[63] != a[63]) begin
				flag(ST_SAT);
				r = a[63] ? QMinNeg : QMaxPos;
			end
			return r;
		endfunction

		function logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
			logic [63:0] r;
			r = a - b;
			if (a[63] != b[63] && r[63] != a[63]) begin
				flag(ST_SAT);
				r = a[63] ? QMinNeg : QMaxPos;
			end
			return r;
		endfunction

		function logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
			logic [127:0] p;
			p = {64'd0, mag(a)} * {64'd0, mag(b)};
			return clamp(a[63] != b[63], p[95:32], p[127:96] != 0);
		endfunction

		function logic [63:0] q_div(logic [63:0] a, logic [63:0] b);
			logic [127:0] q;
			if (mag(b) == 0) begin
				flag(ST_DIVZ);
				return 64'd0;
			end
			q = {32'd0, mag(a), 32'd0} / {64'd0, mag(b)};
			return clamp(a[63] != b[63], q[63:0], q[127:64] != 0);
		endfunction

		function logic [63:0] q_pow(logic [63:0] base, logic [63:0] ex);
			logic [63:0] m;
			logic [63:0] cnt;
			logic [63:0] acc;
			m = mag(ex);
			cnt = {32'd0, m[63:32]} + ((m[31:0] != 0) ? 64'd1 : 64'd0);
			if (cnt > MaxExponentDef) begin
				cnt = MaxExponentDef;
			end
			acc = QOne;
			for (int k = 0; k < int'(cnt); k++) begin
				acc = q_mul(acc, base);
			end
			if (ex[63]) begin
				acc = q_div(QOne, acc);
			end
			return acc;
		endfunction

		function void note_token(token_t t);
			logic [63:0] a;
			logic [63:0] b;
			logic [63:0] r;
			rpn_answer_t ans;
			tokens_seen++;
			if (t.kind == 1'b0) begin
				if (depth >= StackDepthDef) begin
					flag(ST_OVER);
				end else begin
					stack_mem[depth] = t.value;
					depth++;
				end
			end else if (depth < 2) begin
				flag(ST_UNDER);
			end else begin
				b = stack_mem[depth-1];
				a = stack_mem[depth-2];
				case (t.op)
					OP_ADD: r = q_add(a, b);
					OP_SUB: r = q_sub(a, b);
					OP_MUL: r = q_mul(a, b);
					OP_DIV: r = q_div(a, b);
					OP_POW: r = q_pow(a, b);
					default: r = 64'd0;
				endcase
				depth--;
				stack_mem[depth-1] = r;
			end
			if (t.last) begin
				if (depth == 0) begin
					flag(ST_UNDER);
					ans.value = 64'd0;
				end else begin
					ans.value = stack_mem[depth-1];
				end
				ans.st = err;
				answers.push_back(ans);
				depth = 0;
				err = ST_OK;
				exprs_seen++;
			end
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("MISMATCH %s: got %h want %h", what, got, want);
		endtask

		task check_result(logic [63:0] value, logic [2:0] st);
			rpn_answer_t ans;
			if (answers.size() == 0) begin
				report_mismatch("unexpected result", value, 64'd0);
				return;
			end
			ans = answers.pop_front();
			if (value !== ans.value) begin
				report_mismatch("result_value", value, ans.value);
			end
			if (st !== ans.st) begin
				report_mismatch("status", {61'd0, st}, {61'd0, ans.st});
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        kind;
	logic [63:0] token_value;
	logic [2:0]  op_code;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] result_value;
	logic [2:0]  status;

	rpn_scoreboard sb;
	token_t        tok_q [$];
	int unsigned   send_pct;
	int unsigned   recv_pct;
	bit            hold_req;
	int unsigned   quiet_cycles;
	int unsigned   gen_depth;

	postfix_expression_evaluator_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .token_value(token_value), .op_code(op_code), .last(last),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		sb = new();
		in_valid = 1'b0;
		kind = 1'b0;
		token_value = 64'd0;
		op_code = 3'd0;
		last = 1'b0;
		out_ready = 1'b0;
		send_pct = 0;
		recv_pct = 0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_token('{kind: kind, value: token_value, op: op_code, last: last});
			end
			if (out_valid && out_ready) begin
				sb.check_result(result_value, status);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WatchdogLimit) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold = HoldCycles;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_pct);
			end
		end
	end

	function automatic logic [63:0] rand_q();
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return QMaxPos;
			2: return QMinNeg;
			3: return 64'd0;
			4: return {32'd0, $urandom} >> $urandom_range(31);
			default: return {{28{1'b0}}, 4'($urandom_range(15)), $urandom} *
				($urandom_range(1) ? 64'd1 : -64'd1);
		endcase
	endfunction

	task automatic add_tok(logic k, logic [63:0] v, logic [2:0] op, logic l);
		tok_q.push_back('{kind: k, value: v, op: op, last: l});
	endtask

	task automatic gen_expr(int unsigned n_ops);
		int unsigned ops;
		logic [2:0]  op;
		gen_depth = 0;
		ops = 0;
		while (ops < n_ops) begin
			if (gen_depth < 2 || $urandom_range(2) == 0) begin
				add_tok(1'b0, rand_q(), 3'($urandom), 1'b0);
				gen_depth++;
			end else begin
				op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) :
					3'($urandom_range(4));
				add_tok(1'b1, {$urandom, $urandom}, op, 1'b0);
				gen_depth--;
				ops++;
			end
		end
		while (gen_depth > 1) begin
			add_tok(1'b1, {$urandom, $urandom}, 3'($urandom_range(4)), 1'b0);
			gen_depth--;
		end
		if (gen_depth == 0) begin
			add_tok(1'b0, rand_q(), 3'($urandom), 1'b1);
		end else begin
			tok_q[$].last = 1'b1;
		end
	endtask

	task automatic gen_random(int unsigned n_tokens);
		int unsigned goal;
		goal = tok_q.size() + n_tokens;
		while (tok_q.size() < goal) begin
			case ($urandom_range(19))
				0, 1: add_tok(1'($urandom), {$urandom, $urandom}, 3'($urandom),
					1'($urandom));
				2: begin
					repeat (StackDepthDef + 1 + $urandom_range(2))
						add_tok(1'b0, rand_q(), 3'($urandom), 1'b0);
					add_tok(1'b1, {$urandom, $urandom}, OP_ADD, 1'b1);
				end
				3: begin
					add_tok(1'b0, rand_q(), 3'($urandom), 1'b0);
					add_tok(1'b1, {$urandom, $urandom}, 3'($urandom), 1'($urandom));
				end
				default: gen_expr($urandom_range(6));
			endcase
		end
		if (!tok_q[$].last) begin
			add_tok(1'b1, {$urandom, $urandom}, OP_ADD, 1'b1);
		end
	endtask

	task automatic drive_tokens();
		token_t t;
		while (tok_q.size() > 0) begin
			t = tok_q.pop_front();
			while ($urandom_range(99) < send_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			kind <= t.kind;
			token_value <= t.value;
			op_code <= t.op;
			last <= t.last;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.answers.size() > 0) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned sp, int unsigned rp, int unsigned n);
		send_pct = sp;
		recv_pct = rp;
		gen_random(n);
		drive_tokens();
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		add_tok(1'b0, QMaxPos, 3'd0, 1'b0);
		add_tok(1'b0, QMaxPos, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_ADD, 1'b1);
		add_tok(1'b0, QMinNeg, 3'd0, 1'b0);
		add_tok(1'b0, QOne, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_SUB, 1'b1);
		add_tok(1'b0, 64'h0000_0003_8000_0000, 3'd0, 1'b0);
		add_tok(1'b0, -64'sh0000_0002_0000_0000, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_MUL, 1'b1);
		add_tok(1'b0, 64'h0000_0007_0000_0000, 3'd0, 1'b0);
		add_tok(1'b0, 64'd0, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_DIV, 1'b1);
		add_tok(1'b0, 64'h0000_0002_0000_0000, 3'd0, 1'b0);
		add_tok(1'b0, 64'h0000_0002_4000_0000, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_POW, 1'b1);
		add_tok(1'b0, 64'd0, 3'd0, 1'b0);
		add_tok(1'b0, -64'sh0000_0001_0000_0000, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_POW, 1'b1);
		add_tok(1'b0, QOne, 3'd0, 1'b0);
		add_tok(1'b0, QOne, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, 3'd5, 1'b1);
		add_tok(1'b1, 64'd0, OP_ADD, 1'b1);
		add_tok(1'b0, QMinNeg, 3'd0, 1'b0);
		add_tok(1'b0, -64'sh0000_0001_0000_0000, 3'd0, 1'b0);
		add_tok(1'b1, 64'd0, OP_DIV, 1'b1);
		drive_tokens();

		run_phase(0, 0, 80);
		run_phase(78, 0, 80);
		run_phase(0, 78, 80);
		run_phase(23, 23, 80);
		hold_req = 1'b1;
		run_phase(0, 0, 80);

		repeat (800) @(posedge clk);
		$display("Ran %0d tokens forming %0d expressions over idle, stall and hold phases.",
			sb.tokens_seen, sb.exprs_seen);
		if (sb.errors == 0 && sb.answers.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
